### design/imt_pkg.sv
package imt_pkg;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_PROMOTE = 3'd1,
        OP_GET_MAX = 3'd2,
        OP_POP_MAX = 3'd3,
        OP_QUERY   = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BAD_ID = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
    } t_scan_ctl;

endpackage

### design/imt_ram.sv
module imt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/imt_scan.sv
module imt_scan #(
    parameter int IDX_BITS      = 8,
    parameter int PRIORITY_BITS = 16,
    parameter int DATA_BITS     = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  imt_pkg::t_scan_ctl       i_ctl,
    input  logic [IDX_BITS-1:0]      i_idx,
    input  logic                     i_rd_valid,
    input  logic [PRIORITY_BITS-1:0] i_rd_prio,
    input  logic [DATA_BITS-1:0]     i_rd_pay,
    output logic                     o_found,
    output logic [IDX_BITS-1:0]      o_best_idx,
    output logic [PRIORITY_BITS-1:0] o_best_prio,
    output logic [DATA_BITS-1:0]     o_best_pay
);

    logic                     r_smp_vld;
    logic [IDX_BITS-1:0]      r_smp_idx;
    logic                     r_found;
    logic [IDX_BITS-1:0]      r_best_idx;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic [DATA_BITS-1:0]     r_best_pay;
    logic                     take;

    // ascending scan with >= keeps the largest id on a tie
    assign take = r_smp_vld && i_rd_valid && (!r_found || (i_rd_prio >= r_best_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else if (i_ctl.clear) begin
            r_smp_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_smp_vld <= i_ctl.issue;
            if (take) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_smp_idx <= i_idx;
        if (take && !i_ctl.clear) begin
            r_best_idx  <= r_smp_idx;
            r_best_prio <= i_rd_prio;
            r_best_pay  <= i_rd_pay;
        end
    end

    assign o_found     = r_found;
    assign o_best_idx  = r_best_idx;
    assign o_best_prio = r_best_prio;
    assign o_best_pay  = r_best_pay;

`ifndef SYNTHESIS
    a_clear_drops_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear |=> !r_found)
        else $error("scan: found survived a clear");

    a_hold_without_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_smp_vld && !i_ctl.clear) |=> ($stable(r_found) && $stable(r_best_idx)))
        else $error("scan: best changed without a sample");

    a_found_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_found && !r_smp_vld) |=> !r_found)
        else $error("scan: found set without a sample");
`endif

endmodule

### design/indexed_max_priority_table.sv
// Add, promote, query and unused ops go from the accepted request straight to the finish
// step; get max and pop max first scan every id below next_id and drain the last read, or
// skip the scan with no ids yet. Finish waits for a free output; no new request is taken
// until finish ends. The entry RAM's single read port sets the scan length, one read per id.
// Reset clears next_id, control and output valid; entries at or above next_id read as empty,
// so the RAM needs no clearing pass.
module indexed_max_priority_table #(
    parameter int TABLE_DEPTH   = 256,
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_op,
    input  logic [7:0]  i_id,
    input  logic [31:0] i_payload,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [7:0]  o_result_id,
    output logic [31:0] o_result_payload,
    output logic [15:0] o_result_priority,
    output logic        o_is_valid
);

    localparam int IW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam int WW   = 1 + PRIORITY_BITS + DATA_BITS;

    imt_pkg::t_state    r_state, n_state;
    logic [2:0]         r_op;
    logic [7:0]         r_id;
    logic               r_id_ok;
    logic [IW-1:0]      r_addr;
    logic [DATA_BITS-1:0] r_pay;
    logic [CW-1:0]      r_next_id;
    logic [IW-1:0]      r_scan_addr;

    logic               r_out_valid;
    imt_pkg::t_status   r_status;
    logic [7:0]         r_rid;
    logic [31:0]        r_rpay;
    logic [15:0]        r_rprio;
    logic               r_isv;

    imt_pkg::t_status   n_status;
    logic [7:0]         n_rid;
    logic [31:0]        n_rpay;
    logic [15:0]        n_rprio;
    logic               n_isv;

    logic               in_acc;
    logic               out_free;
    logic               fin;
    logic               scan_last;
    logic [CMPW-1:0]    id_ext;
    logic               id_ok;
    logic [CW-1:0]      next_m1;
    logic               tbl_full;
    logic               in_lookup;
    logic               in_scan;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [WW-1:0]      ram_wdata;
    logic               ram_re;
    logic [IW-1:0]      ram_raddr;
    logic [WW-1:0]      ram_rdata;
    logic               next_inc;

    logic                     rd_valid;
    logic [PRIORITY_BITS-1:0] rd_prio;
    logic [DATA_BITS-1:0]     rd_pay;
    logic [PRIORITY_BITS-1:0] prio_inc;

    imt_pkg::t_scan_ctl       scan_ctl;
    logic                     sc_found;
    logic [IW-1:0]            sc_idx;
    logic [PRIORITY_BITS-1:0] sc_prio;
    logic [DATA_BITS-1:0]     sc_pay;

    logic [63:0] pay_in_w;
    logic [63:0] rd_pay_w;
    logic [63:0] sc_pay_w;
    logic [63:0] r_pay_w;
    logic [31:0] inc_prio_w;
    logic [31:0] rd_prio_w;
    logic [31:0] sc_prio_w;
    logic [31:0] nid_w;
    logic [15:0] sc_idx_w;

    assign id_ext    = CMPW'(i_id);
    assign id_ok     = id_ext < CMPW'(r_next_id);
    assign next_m1   = r_next_id - 1'b1;
    assign scan_last = (CW'(r_scan_addr) == next_m1);
    assign tbl_full  = (r_next_id == CW'(TABLE_DEPTH));
    assign in_lookup = (i_op == imt_pkg::OP_PROMOTE) || (i_op == imt_pkg::OP_QUERY);
    assign in_scan   = (i_op == imt_pkg::OP_GET_MAX) || (i_op == imt_pkg::OP_POP_MAX);
    assign out_free  = !r_out_valid || i_out_ready;
    assign in_acc    = i_in_valid && o_in_ready;

    assign rd_valid = ram_rdata[WW-1];
    assign rd_prio  = ram_rdata[DATA_BITS +: PRIORITY_BITS];
    assign rd_pay   = ram_rdata[DATA_BITS-1:0];
    assign prio_inc = (rd_prio == {PRIORITY_BITS{1'b1}}) ? rd_prio : rd_prio + 1'b1;

    assign pay_in_w   = 64'(i_payload);
    assign rd_pay_w   = 64'(rd_pay);
    assign sc_pay_w   = 64'(sc_pay);
    assign r_pay_w    = 64'(r_pay);
    assign inc_prio_w = 32'(prio_inc);
    assign rd_prio_w  = 32'(rd_prio);
    assign sc_prio_w  = 32'(sc_prio);
    assign nid_w      = 32'(r_next_id);
    assign sc_idx_w   = 16'(sc_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            imt_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (in_scan && (r_next_id != '0)) begin
                        n_state = imt_pkg::S_SCAN;
                    end else begin
                        n_state = imt_pkg::S_FINISH;
                    end
                end
            end
            imt_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = imt_pkg::S_DRAIN;
                end
            end
            imt_pkg::S_DRAIN: begin
                n_state = imt_pkg::S_FINISH;
            end
            imt_pkg::S_FINISH: begin
                if (out_free) begin
                    n_state = imt_pkg::S_IDLE;
                end
            end
            default: n_state = imt_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready     = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = r_scan_addr;
        scan_ctl.clear = 1'b0;
        scan_ctl.issue = 1'b0;
        fin            = 1'b0;
        unique case (r_state)
            imt_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                ram_re         = i_in_valid && in_lookup && id_ok;
                ram_raddr      = id_ext[IW-1:0];
                scan_ctl.clear = i_in_valid;
            end
            imt_pkg::S_SCAN: begin
                ram_re         = 1'b1;
                scan_ctl.issue = 1'b1;
            end
            imt_pkg::S_DRAIN: begin
            end
            imt_pkg::S_FINISH: begin
                fin = out_free;
            end
            default: begin
            end
        endcase
    end

    // result and write-back
    always_comb begin
        n_status  = imt_pkg::ST_OK;
        n_rid     = '0;
        n_rpay    = '0;
        n_rprio   = '0;
        n_isv     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {1'b1, prio_inc, rd_pay};
        next_inc  = 1'b0;
        case (r_op) inside
            imt_pkg::OP_ADD: begin
                if (tbl_full) begin
                    n_status = imt_pkg::ST_FULL;
                end else begin
                    n_rid     = nid_w[7:0];
                    n_rpay    = r_pay_w[31:0];
                    ram_we    = fin;
                    next_inc  = fin;
                    ram_waddr = r_next_id[IW-1:0];
                    ram_wdata = {1'b1, {PRIORITY_BITS{1'b0}}, r_pay};
                end
            end
            imt_pkg::OP_PROMOTE: begin
                n_rid = r_id;
                if (!r_id_ok || !rd_valid) begin
                    n_status = imt_pkg::ST_BAD_ID;
                end else begin
                    n_rpay  = rd_pay_w[31:0];
                    n_rprio = inc_prio_w[15:0];
                    ram_we  = fin;
                end
            end
            imt_pkg::OP_QUERY: begin
                n_rid = r_id;
                if (!r_id_ok || !rd_valid) begin
                    n_status = imt_pkg::ST_BAD_ID;
                end else begin
                    n_rpay  = rd_pay_w[31:0];
                    n_rprio = rd_prio_w[15:0];
                    n_isv   = 1'b1;
                end
            end
            imt_pkg::OP_GET_MAX, imt_pkg::OP_POP_MAX: begin
                if (!sc_found) begin
                    n_status = imt_pkg::ST_EMPTY;
                end else begin
                    n_rid     = sc_idx_w[7:0];
                    n_rpay    = sc_pay_w[31:0];
                    n_rprio   = sc_prio_w[15:0];
                    // drop the winner on pop
                    ram_we    = fin && (r_op == imt_pkg::OP_POP_MAX);
                    ram_waddr = sc_idx;
                    ram_wdata = {1'b0, sc_prio, sc_pay};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= imt_pkg::S_IDLE;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
            r_scan_addr <= '0;
        end else begin
            r_state <= n_state;
            if (next_inc) begin
                r_next_id <= r_next_id + 1'b1;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_scan_addr <= '0;
            end else if (r_state == imt_pkg::S_SCAN) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_op;
            r_id    <= i_id;
            r_id_ok <= id_ok;
            r_addr  <= id_ext[IW-1:0];
            r_pay   <= pay_in_w[DATA_BITS-1:0];
        end
        if (fin) begin
            r_status <= n_status;
            r_rid    <= n_rid;
            r_rpay   <= n_rpay;
            r_rprio  <= n_rprio;
            r_isv    <= n_isv;
        end
    end

    imt_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    imt_scan #(
        .IDX_BITS      (IW),
        .PRIORITY_BITS (PRIORITY_BITS),
        .DATA_BITS     (DATA_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_idx       (r_scan_addr),
        .i_rd_valid  (rd_valid),
        .i_rd_prio   (rd_prio),
        .i_rd_pay    (rd_pay),
        .o_found     (sc_found),
        .o_best_idx  (sc_idx),
        .o_best_prio (sc_prio),
        .o_best_pay  (sc_pay)
    );

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_result_id       = r_rid;
    assign o_result_payload  = r_rpay;
    assign o_result_priority = r_rprio;
    assign o_is_valid        = r_isv;

`ifndef SYNTHESIS
    a_next_id_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id <= CW'(TABLE_DEPTH))
        else $error("next_id ran past the table depth");

    a_write_only_at_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == imt_pkg::S_FINISH))
        else $error("entry RAM written outside the finish step");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == imt_pkg::S_SCAN) |-> (CW'(r_scan_addr) < r_next_id))
        else $error("scan address beyond the allocated ids");

    a_next_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_next_id != $past(r_next_id)))
            |-> (r_next_id == $past(r_next_id) + 1'b1))
        else $error("next_id moved by more than one");
`endif

endmodule
